FILE: hdl/ciop_pkg.sv
// -----------------------------------------------------------------------------
// ciop_pkg
// shared types and constants of the processor i/o port with bit discharge
// -----------------------------------------------------------------------------
package ciop_pkg;

   // command codes of an input transaction
   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_READ_PORT = 3'd1,
      CMD_READ_DIR  = 3'd2,
      CMD_WRITE_PORT = 3'd3,
      CMD_WRITE_DIR = 3'd4
   } cmd_type;

   // csr register indexes
   typedef enum logic [0:0] {
      REG_DISCHARGE_LENGTH = 1'd0
   } reg_index_type;

   localparam int LENGTH_WIDTH = 20;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [LENGTH_WIDTH-1:0] LENGTH_RESET = 20'd350000;
   localparam logic [7:0] PORT_RESET = 8'hFF;

   localparam logic [7:0] PULL_UP_LOW = 8'h07;
   localparam logic [7:0] BIT3_MASK   = 8'h08;
   localparam logic [7:0] PLAY_MASK   = 8'h10;
   localparam logic [7:0] MOTOR_MASK  = 8'h20;
   localparam logic [7:0] BIT6_MASK   = 8'h40;
   localparam logic [7:0] BIT7_MASK   = 8'h80;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] write_value;
      logic       play_key_pressed;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       motor_on;
   } rsp_type;

endpackage

FILE: hdl/cpu_io_port_with_bit_discharge_top.sv
// -----------------------------------------------------------------------------
// cpu_io_port_with_bit_discharge_top
// 8-bit processor i/o port with data and direction registers, tape motor
// drive and timed discharge of floating high bits 6 and 7
// -----------------------------------------------------------------------------
//
//   channel   handshake              payload / access
//   -------   --------------------   -------------------------------------
//   req       req_valid, req_ready   req_payload: command, value, play key
//   rsp       rsp_valid, rsp_ready   rsp_payload: read_data, motor_on
//   csr       psel/penable/pready    byte 0: discharge_length (20 bits)
//
// one transaction per cycle sustained while rsp_ready stays high; a result
// is valid once its request has passed the input register and then the
// result register
// the whole command is decoded and applied between the input register and
// the result register, so the port state is updated once per transaction
// synchronous active-high reset; no clearing pass, state resets at once
// a stalled result register holds its transaction while the input register
// can still take one more; req_ready falls only when both are full
//
module cpu_io_port_with_bit_discharge_top import ciop_pkg::*; #(
   parameter int COUNT_WIDTH = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_payload,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_payload,
   // csr port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic                    in_valid_ff, in_valid_in;
   req_type                 in_item_ff;
   logic                    out_valid_ff, out_valid_in;
   rsp_type                 out_item_ff;
   logic [LENGTH_WIDTH-1:0] length_ff;
   logic                    advance;
   logic                    req_take;
   logic                    csr_write;
   logic                    csr_hit;
   rsp_type                 result;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   // register index is the word address
   assign csr_hit    = csr_paddr[CSR_ADDR_WIDTH-1] == REG_DISCHARGE_LENGTH;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? CSR_DATA_WIDTH'(length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LENGTH_RESET;
      end else if (csr_write && csr_hit) begin
         length_ff <= csr_pwdata[LENGTH_WIDTH-1:0];
      end
   end

   // ---------------------------------------------------------------- pipeline
   // the input register moves on whenever the result register is free or drains
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign req_take    = req_valid && req_ready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_item_ff  <= req_payload;
      if (advance)  out_item_ff <= result;
   end

   // port state and command execution
   ciop_port_regs #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_port_regs (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .length (length_ff),
      .result (result)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

FILE: hdl/ciop_port_regs.sv
// -----------------------------------------------------------------------------
// ciop_port_regs
// port, direction, float and discharge state; computes one result per command
// -----------------------------------------------------------------------------
module ciop_port_regs import ciop_pkg::*; #(
   parameter int COUNT_WIDTH = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  req_type                 item,
   input  logic [LENGTH_WIDTH-1:0] length,
   output rsp_type                 result
);

   localparam logic [63:0] CNT_MAX64 = (64'd1 << COUNT_WIDTH) - 64'd1;

   logic [7:0]             port_ff, port_in;
   logic [7:0]             dir_ff, dir_in;
   logic                   bit3_ff, bit3_in;
   logic [COUNT_WIDTH-1:0] cnt6_ff, cnt6_in;
   logic [COUNT_WIDTH-1:0] cnt7_ff, cnt7_in;
   logic                   motor_ff, motor_in;

   logic [COUNT_WIDTH-1:0] load_value;
   logic [7:0]             pull_bits;
   logic [7:0]             falling;
   logic [7:0]             read_data;

   // saturate the length when the countdown is narrower than the register
   always_comb begin
      if (64'(length) > CNT_MAX64) begin
         load_value = COUNT_WIDTH'(CNT_MAX64);
      end else begin
         load_value = COUNT_WIDTH'(64'(length));
      end
   end

   always_comb begin
      pull_bits = PULL_UP_LOW;
      if (bit3_ff)                pull_bits = pull_bits | BIT3_MASK;
      if (!item.play_key_pressed) pull_bits = pull_bits | PLAY_MASK;
      if (cnt6_ff != '0)          pull_bits = pull_bits | BIT6_MASK;
      if (cnt7_ff != '0)          pull_bits = pull_bits | BIT7_MASK;
   end

   assign falling = dir_ff & ~item.write_value & port_ff;

   always_comb begin
      port_in   = port_ff;
      dir_in    = dir_ff;
      bit3_in   = bit3_ff;
      cnt6_in   = cnt6_ff;
      cnt7_in   = cnt7_ff;
      motor_in  = motor_ff;
      read_data = 8'd0;
      unique case (item.command)
         CMD_TICK: begin
            if (cnt6_ff != '0) cnt6_in = cnt6_ff - COUNT_WIDTH'(1);
            if (cnt7_ff != '0) cnt7_in = cnt7_ff - COUNT_WIDTH'(1);
         end
         CMD_READ_PORT: begin
            read_data = (port_ff & dir_ff) | (pull_bits & ~dir_ff);
         end
         CMD_READ_DIR: begin
            read_data = dir_ff;
         end
         CMD_WRITE_PORT: begin
            port_in = item.write_value;
            // motor drive is low-active
            if ((dir_ff & MOTOR_MASK) != '0) begin
               motor_in = (item.write_value & MOTOR_MASK) == '0;
            end
         end
         CMD_WRITE_DIR: begin
            // becoming an output stops floating; output-to-input with a high bit starts it
            if ((item.write_value & BIT3_MASK) != '0) bit3_in = 1'b0;
            if ((item.write_value & BIT6_MASK) != '0) cnt6_in = '0;
            if ((item.write_value & BIT7_MASK) != '0) cnt7_in = '0;
            if ((falling & BIT3_MASK) != '0) bit3_in = 1'b1;
            if ((falling & BIT6_MASK) != '0) cnt6_in = load_value;
            if ((falling & BIT7_MASK) != '0) cnt7_in = load_value;
            dir_in = item.write_value;
         end
         default: begin
         end
      endcase
   end

   assign result.read_data = read_data;
   assign result.motor_on  = motor_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff  <= PORT_RESET;
         dir_ff   <= '0;
         bit3_ff  <= 1'b0;
         cnt6_ff  <= '0;
         cnt7_ff  <= '0;
         motor_ff <= 1'b0;
      end else if (fire) begin
         port_ff  <= port_in;
         dir_ff   <= dir_in;
         bit3_ff  <= bit3_in;
         cnt6_ff  <= cnt6_in;
         cnt7_ff  <= cnt7_in;
         motor_ff <= motor_in;
      end
   end

endmodule

FILE: hdl/ciop_checker.sv
// -----------------------------------------------------------------------------
// ciop_assertions
// port-level checks of the processor i/o port, bound to the top level
// -----------------------------------------------------------------------------
module ciop_assertions import ciop_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input rsp_type                   rsp_payload,
   input logic                      csr_psel,
   input logic                      csr_penable,
   input logic                      csr_pwrite,
   input logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   input logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   input logic                      csr_pready
);

   // no result is left over from before reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // an empty result side never back-pressures requests
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   // a stalled transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // the length register reads back what was written
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready &&
      csr_paddr[CSR_ADDR_WIDTH-1] == REG_DISCHARGE_LENGTH
      |=> csr_prdata[LENGTH_WIDTH-1:0] == $past(csr_pwdata[LENGTH_WIDTH-1:0]) ||
          csr_paddr[CSR_ADDR_WIDTH-1] != REG_DISCHARGE_LENGTH)
      else $error("discharge length readback mismatch");

endmodule

bind cpu_io_port_with_bit_discharge_top ciop_assertions u_ciop_assertions (.*);

FILE: test/ciop_checker.sv
// -----------------------------------------------------------------------------
// ciop_checker
// watches the request, result and csr channels of the i/o port, keeps its
// own copy of the port state and compares every result in order
// -----------------------------------------------------------------------------
module ciop_checker import ciop_pkg::*; #(
   parameter int COUNT_WIDTH = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_type                   req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_type                   rsp_payload,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic                      csr_pready,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output int                        failures,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_WIDTH-1:0] LENGTH_ADDR =
      CSR_ADDR_WIDTH'(4 * REG_DISCHARGE_LENGTH);

   // port model
   logic [LENGTH_WIDTH-1:0] discharge_len;
   logic [7:0]              port_data;
   logic [7:0]              port_dir;
   logic                    bit3_high;
   logic [COUNT_WIDTH-1:0]  bit6_left;
   logic [COUNT_WIDTH-1:0]  bit7_left;
   logic                    motor_running;

   rsp_type expected_rsp_q[$];
   int      errors = 0;

   assign failures = errors;

   // discharge length clipped to what the countdown can hold
   function automatic logic [COUNT_WIDTH-1:0] load_count();
      longint unsigned ceiling;
      ceiling = (64'd1 << COUNT_WIDTH) - 64'd1;
      if (64'(discharge_len) > ceiling)
         return ceiling[COUNT_WIDTH-1:0];
      return COUNT_WIDTH'(discharge_len);
   endfunction

   function automatic rsp_type port_step(input req_type item);
      rsp_type    outcome;
      logic [7:0] pulls;
      logic [7:0] falling;
      outcome = '0;
      case (item.command)
         CMD_TICK: begin
            if (bit6_left != '0) bit6_left = bit6_left - COUNT_WIDTH'(1);
            if (bit7_left != '0) bit7_left = bit7_left - COUNT_WIDTH'(1);
         end
         CMD_READ_PORT: begin
            pulls = PULL_UP_LOW;
            if (bit3_high) pulls = pulls | BIT3_MASK;
            if (!item.play_key_pressed) pulls = pulls | PLAY_MASK;
            if (bit6_left != '0) pulls = pulls | BIT6_MASK;
            if (bit7_left != '0) pulls = pulls | BIT7_MASK;
            outcome.read_data = (port_data & port_dir) | (pulls & ~port_dir);
         end
         CMD_READ_DIR: outcome.read_data = port_dir;
         CMD_WRITE_PORT: begin
            port_data = item.write_value;
            if ((port_dir & MOTOR_MASK) != '0)
               motor_running = ((item.write_value & MOTOR_MASK) == '0);
         end
         CMD_WRITE_DIR: begin
            // output-to-input change with the port bit high
            falling = port_dir & ~item.write_value & port_data;
            if ((item.write_value & BIT3_MASK) != '0) bit3_high = 1'b0;
            if ((item.write_value & BIT6_MASK) != '0) bit6_left = '0;
            if ((item.write_value & BIT7_MASK) != '0) bit7_left = '0;
            if ((falling & BIT3_MASK) != '0) bit3_high = 1'b1;
            if ((falling & BIT6_MASK) != '0) bit6_left = load_count();
            if ((falling & BIT7_MASK) != '0) bit7_left = load_count();
            port_dir = item.write_value;
         end
         default: ;
      endcase
      outcome.motor_on = motor_running;
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         discharge_len = LENGTH_RESET;
         port_data     = PORT_RESET;
         port_dir      = '0;
         bit3_high     = 1'b0;
         bit6_left     = '0;
         bit7_left     = '0;
         motor_running = 1'b0;
         expected_rsp_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == LENGTH_ADDR)
            discharge_len = csr_pwdata[LENGTH_WIDTH-1:0];
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t unexpected result: expected none, actual %p", $time, rsp_payload);
               errors++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_payload.read_data !== want.read_data) begin
                  $display("%0t read_data mismatch: expected %h, actual %h",
                           $time, want.read_data, rsp_payload.read_data);
                  errors++;
               end
               if (rsp_payload.motor_on !== want.motor_on) begin
                  $display("%0t motor_on mismatch: expected %b, actual %b",
                           $time, want.motor_on, rsp_payload.motor_on);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_rsp_q.push_back(port_step(req_payload));
      end
      pending <= expected_rsp_q.size();
   end

endmodule

FILE: test/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// drives the processor i/o port with directed and random command streams
// under several discharge lengths, with random stalls on both channels;
// the checker beside the block predicts and compares every result
// -----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ciop_pkg::*;

   localparam int COUNT_WIDTH    = 20;
   localparam int IDLE_PERCENT   = 6;
   localparam int LONG_HOLD      = 60;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 150;

   // command codes the block ignores
   localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

   localparam logic [CSR_ADDR_WIDTH-1:0] LENGTH_ADDR =
      CSR_ADDR_WIDTH'(4 * REG_DISCHARGE_LENGTH);
   localparam logic [7:0] FLOAT_BITS = BIT3_MASK | BIT6_MASK | BIT7_MASK;

   // every block input known from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_payload;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   int   failures;
   int   pending;

   // stall shaping for sender and receiver
   logic quiet = 1'b0;      // no idling on either side while set
   logic hold_rsp = 1'b0;   // asks the receiver for one long hold-off
   logic hold_done = 1'b0;
   int   hold_count = 0;
   int   stall_cycles = 0;

   always #2 clock = ~clock;

   cpu_io_port_with_bit_discharge_top #(.COUNT_WIDTH(COUNT_WIDTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ciop_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .failures    (failures),
      .pending     (pending)
   );

   // receiver: random back-pressure, plus one long hold-off counted here
   // so the block fills both registers and drops req_ready
   always @(posedge clock) begin
      if (hold_rsp && !hold_done) begin
         hold_done  <= 1'b1;
         hold_count <= LONG_HOLD - 1;
         rsp_ready  <= 1'b0;
      end else if (hold_count != 0) begin
         hold_count <= hold_count - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // offer one request transaction and hold it until it is taken;
   // a random gap with valid low may come first, never between raise and take
   task automatic send(input logic [2:0] command, input logic [7:0] value,
                       input logic play);
      req_type item;
      item.command          = command;
      item.write_value      = value;
      item.play_key_pressed = play;
      if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // sender pause: nothing offered until every result is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // two-phase csr write, block idle
   task automatic write_length(input logic [CSR_DATA_WIDTH-1:0] length);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LENGTH_ADDR;
      csr_pwdata  <= length;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // random stream: mostly discharge sequences (set bits high as outputs,
   // release them, then tick and read while they run out), the rest loose
   // commands of every kind including the ignored codes
   task automatic random_items(input int count, input int max_ticks);
      int         sent;
      int         steps;
      int         pick;
      logic [7:0] value;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 30) begin
            send(CMD_WRITE_PORT, 8'($urandom_range(255)) | FLOAT_BITS, 1'($urandom_range(1)));
            send(CMD_WRITE_DIR, 8'($urandom_range(255)) | FLOAT_BITS, 1'($urandom_range(1)));
            send(CMD_WRITE_DIR, 8'($urandom_range(255)) & ~FLOAT_BITS, 1'($urandom_range(1)));
            steps = $urandom_range(max_ticks, 1);
            sent += 3 + 2 * steps;
            repeat (steps) begin
               send(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
               send(CMD_READ_PORT, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
         end else begin
            pick  = $urandom_range(99);
            value = 8'($urandom_range(255));
            if (pick < 30)
               send(CMD_TICK, value, 1'($urandom_range(1)));
            else if (pick < 55)
               send(CMD_READ_PORT, value, 1'($urandom_range(1)));
            else if (pick < 62)
               send(CMD_READ_DIR, value, 1'($urandom_range(1)));
            else if (pick < 75)
               send(CMD_WRITE_PORT, value, 1'($urandom_range(1)));
            else if (pick < 94)
               send(CMD_WRITE_DIR, value, 1'($urandom_range(1)));
            else
               send(3'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED)), value,
                    1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   initial begin
      int unsigned phase_length [6];
      int          span;
      phase_length = '{0, 1048575, 1, 3, 12, 0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: pull levels, play key, empty direction register
      send(CMD_READ_PORT, 8'h00, 1'b0);
      send(CMD_READ_PORT, 8'hFF, 1'b1);
      send(CMD_READ_DIR, 8'h00, 1'b0);
      // all outputs, motor on then off through bit 5
      send(CMD_WRITE_DIR, 8'hFF, 1'b0);
      send(CMD_READ_PORT, 8'h00, 1'b1);
      send(CMD_WRITE_PORT, 8'h00, 1'b0);
      send(CMD_WRITE_PORT, 8'hFF, 1'b1);
      // release every bit with the port high: bit 3 floats, 6 and 7 discharge
      send(CMD_WRITE_DIR, 8'h00, 1'b0);
      send(CMD_READ_PORT, 8'h00, 1'b0);
      send(CMD_TICK, 8'hFF, 1'b0);
      send(CMD_READ_PORT, 8'h00, 1'b1);
      // port write with bit 5 an input leaves the motor alone
      send(CMD_WRITE_PORT, 8'h00, 1'b0);
      send(CMD_WRITE_PORT, 8'hFF, 1'b0);
      // ignored command codes
      for (int code = CMD_FIRST_UNUSED; code <= CMD_LAST_UNUSED; code++)
         send(3'(code), (code % 2 != 0) ? 8'hAA : 8'h55, 1'(code % 2));

      // zero length: released bits 6 and 7 read low at once
      wait_for_results();
      write_length(32'd0);
      send(CMD_WRITE_DIR, FLOAT_BITS, 1'b0);
      send(CMD_READ_PORT, 8'h00, 1'b0);
      send(CMD_WRITE_DIR, 8'h00, 1'b0);
      send(CMD_READ_PORT, 8'h00, 1'b0);

      // short length: discharge runs out after two ticks
      wait_for_results();
      write_length(32'd2);
      send(CMD_WRITE_DIR, 8'hFF, 1'b1);
      send(CMD_WRITE_DIR, 8'h00, 1'b0);
      send(CMD_READ_PORT, 8'h00, 1'b0);
      send(CMD_TICK, 8'h00, 1'b0);
      send(CMD_TICK, 8'h00, 1'b1);
      send(CMD_READ_PORT, 8'h00, 1'b0);
      send(CMD_READ_DIR, 8'h00, 1'b0);

      // random phases, each under its own discharge length
      foreach (phase_length[i]) begin
         if (i == 5)
            phase_length[i] = $urandom_range(30);
         wait_for_results();
         quiet <= (i == 2);                    // long stretch without idling
         if (i == 3)
            hold_rsp <= 1'b1;                  // long receiver hold-off
         write_length(phase_length[i]);
         span = (phase_length[i] > 30) ? 33 : int'(phase_length[i]) + 3;
         if (i == 4) begin
            random_items(PHASE_ITEMS / 2, span);
            wait_for_results();
            random_items(PHASE_ITEMS / 2, span);
         end else begin
            random_items(PHASE_ITEMS, span);
         end
      end

      // drain and let the pipeline settle
      wait_for_results();
      repeat (4) @(posedge clock);

      if (failures == 0 && pending == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
